>>> src/one_wire_master_defines.svh
// Assertion macros used by the one-wire master top level.
`ifndef ONE_WIRE_MASTER_DEFINES_SVH
`define ONE_WIRE_MASTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OWM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define OWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/owm_pkg.sv
// Types, constants and helpers of the one-wire master.
package owm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int TIME_WIDTH    = 10;
   localparam int CFG_W         = 10;
   localparam int CNT_W         = $clog2(BITS_PER_BYTE + 1);
   localparam int IDX_W         = 3;
   localparam int CSR_IDX_W     = 3;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [CFG_W-1:0]      cfg_word_type;

   typedef enum logic [2:0] {
      OP_RESET = 3'd0,
      OP_WBYTE = 3'd1,
      OP_RBYTE = 3'd2,
      OP_RBIT  = 3'd3,
      OP_WBIT  = 3'd4
   } op_type;

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_LOW    = 7'b0000010,
      PH_WAIT   = 7'b0000100,
      PH_SAMPLE = 7'b0001000,
      PH_TAIL   = 7'b0010000,
      PH_HOLD   = 7'b0100000,
      PH_WREC   = 7'b1000000
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESET_LOW      = 3'd0,
      CSR_PRESENCE_DELAY = 3'd1,
      CSR_RESET_RECOVERY = 3'd2,
      CSR_SLOT_LOW       = 3'd3,
      CSR_READ_DELAY     = 3'd4,
      CSR_READ_TAIL      = 3'd5,
      CSR_WRITE_HOLD     = 3'd6,
      CSR_WRITE_RECOVERY = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic       start_req;
      logic [2:0] mode;
      logic [7:0] tx_value;
      logic       line_in;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] rx_value;
   } rsp_type;

   typedef struct packed {
      cfg_word_type reset_low_time;
      cfg_word_type presence_sample_delay;
      cfg_word_type reset_recovery_time;
      cfg_word_type slot_low_time;
      cfg_word_type read_sample_delay;
      cfg_word_type read_tail_time;
      cfg_word_type write_hold_time;
      cfg_word_type write_recovery_time;
   } cfg_type;

   function automatic time_type to_time(input cfg_word_type v);
      return TIME_WIDTH'(v);
   endfunction

   function automatic time_type at_least_one(input time_type v);
      return (v == '0) ? time_type'(1) : v;
   endfunction

endpackage

>>> src/owm_cfg_regs.sv
// Timing register file of the one-wire master.
module owm_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [owm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [owm_pkg::CFG_W-1:0]        csr_data,
   output owm_pkg::cfg_type                 cfg
);
   import owm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_RESET_LOW:      cfg_in.reset_low_time        = csr_data;
            CSR_PRESENCE_DELAY: cfg_in.presence_sample_delay = csr_data;
            CSR_RESET_RECOVERY: cfg_in.reset_recovery_time   = csr_data;
            CSR_SLOT_LOW:       cfg_in.slot_low_time         = csr_data;
            CSR_READ_DELAY:     cfg_in.read_sample_delay     = csr_data;
            CSR_READ_TAIL:      cfg_in.read_tail_time        = csr_data;
            CSR_WRITE_HOLD:     cfg_in.write_hold_time       = csr_data;
            CSR_WRITE_RECOVERY: cfg_in.write_recovery_time   = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time        <= CFG_W'(480);
         cfg_ff.presence_sample_delay <= CFG_W'(100);
         cfg_ff.reset_recovery_time   <= CFG_W'(380);
         cfg_ff.slot_low_time         <= CFG_W'(2);
         cfg_ff.read_sample_delay     <= CFG_W'(10);
         cfg_ff.read_tail_time        <= CFG_W'(49);
         cfg_ff.write_hold_time       <= CFG_W'(58);
         cfg_ff.write_recovery_time   <= CFG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/owm_core.sv
// Slot sequencer of the one-wire master: phase, timer, bit counter and shifters.
module owm_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  owm_pkg::req_type  req,
   input  owm_pkg::cfg_type  cfg,
   output owm_pkg::rsp_type  rsp
);
   import owm_pkg::*;

   phase_type              phase_ff, phase_in;
   op_type                 op_ff, op_in;
   time_type               time_ff, time_in;
   logic [CNT_W-1:0]       bits_ff, bits_in;
   logic [7:0]             shout_ff, shout_in;
   logic [7:0]             shin_ff, shin_in;
   logic                   pres_ff, pres_in;

   logic                   start_ok;
   logic                   is_rst;
   logic                   is_wr;
   logic                   end_slot;
   logic                   drive;
   logic                   busy;
   logic                   done;
   logic [CNT_W-1:0]       total;
   logic [CNT_W-1:0]       idx_full;
   logic [IDX_W-1:0]       idx;
   time_type               low_t;
   time_type               wait_t;
   time_type               tail_t;
   time_type               hold_t;
   time_type               wrec_t;

   assign start_ok = (phase_ff == PH_IDLE) && req.start_req &&
                     (req.mode inside {[OP_RESET:OP_WBIT]});

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      time_in  = time_ff;
      bits_in  = bits_ff;
      shout_in = shout_ff;
      shin_in  = shin_ff;
      pres_in  = pres_ff;
      drive    = 1'b0;
      busy     = 1'b0;
      done     = 1'b0;
      end_slot = 1'b0;

      // launch: operation kind first, slot times follow from it
      if (start_ok) begin
         op_in    = op_type'(req.mode);
         bits_in  = (op_in == OP_WBYTE || op_in == OP_RBYTE) ?
                    CNT_W'(BITS_PER_BYTE) : CNT_W'(1);
         shout_in = (op_in == OP_WBIT) ? {7'b0, req.tx_value[0]} : req.tx_value;
         if (op_in == OP_RBYTE || op_in == OP_RBIT) begin
            shin_in = '0;
         end
         if (op_in == OP_RESET) begin
            pres_in = 1'b0;
         end
         phase_in = PH_LOW;
      end

      is_rst = (op_in == OP_RESET);
      is_wr  = (op_in == OP_WBYTE) || (op_in == OP_WBIT);
      low_t  = at_least_one(is_rst ? to_time(cfg.reset_low_time)
                                   : to_time(cfg.slot_low_time));
      wait_t = is_rst ? at_least_one(to_time(cfg.presence_sample_delay))
                      : to_time(cfg.read_sample_delay);
      tail_t = is_rst ? to_time(cfg.reset_recovery_time)
                      : to_time(cfg.read_tail_time);
      hold_t = at_least_one(to_time(cfg.write_hold_time));
      wrec_t = to_time(cfg.write_recovery_time);

      if (start_ok) begin
         time_in = low_t;
      end

      total    = (op_in == OP_RBYTE) ? CNT_W'(BITS_PER_BYTE) : CNT_W'(1);
      idx_full = total - bits_in;
      idx      = idx_full[IDX_W-1:0];

      if (phase_in != PH_IDLE) begin
         busy  = 1'b1;
         drive = (phase_in == PH_LOW) || ((phase_in == PH_HOLD) && !shout_in[0]);

         if (phase_in == PH_SAMPLE) begin
            if (is_rst) begin
               pres_in = !req.line_in;
            end else begin
               shin_in[idx] = shin_in[idx] | req.line_in;
            end
         end

         time_in = time_in - time_type'(1);
         if (time_in == '0) begin
            case (phase_in)
               PH_LOW: begin
                  if (is_wr) begin
                     phase_in = PH_HOLD;
                     time_in  = hold_t;
                  end else if (wait_t != '0) begin
                     phase_in = PH_WAIT;
                     time_in  = wait_t;
                  end else begin
                     phase_in = PH_SAMPLE;
                     time_in  = time_type'(1);
                  end
               end
               PH_WAIT: begin
                  phase_in = PH_SAMPLE;
                  time_in  = time_type'(1);
               end
               PH_SAMPLE: begin
                  if (tail_t != '0) begin
                     phase_in = PH_TAIL;
                     time_in  = tail_t;
                  end else begin
                     end_slot = 1'b1;
                  end
               end
               PH_HOLD: begin
                  if (wrec_t != '0) begin
                     phase_in = PH_WREC;
                     time_in  = wrec_t;
                  end else begin
                     end_slot = 1'b1;
                  end
               end
               default: end_slot = 1'b1;
            endcase
         end

         // slot over: advance to the next bit or finish
         if (end_slot) begin
            bits_in  = bits_in - CNT_W'(1);
            shout_in = shout_in >> 1;
            if (bits_in == '0) begin
               phase_in = PH_IDLE;
               time_in  = '0;
               done     = 1'b1;
            end else begin
               phase_in = PH_LOW;
               time_in  = low_t;
            end
         end
      end
   end

   assign rsp.drive_low = drive;
   assign rsp.busy_res  = busy;
   assign rsp.done_res  = done;
   assign rsp.presence  = pres_in;
   assign rsp.rx_value  = shin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= OP_RESET;
         time_ff  <= '0;
         bits_ff  <= '0;
         shout_ff <= '0;
         shin_ff  <= '0;
         pres_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         time_ff  <= time_in;
         bits_ff  <= bits_in;
         shout_ff <= shout_in;
         shin_ff  <= shin_in;
         pres_ff  <= pres_in;
      end
   end

endmodule

>>> src/one_wire_master.sv
// One-wire bus master: each accepted request word is one microsecond tick of bus
// timing and yields exactly one response word with the line drive, busy, done,
// presence and received data of that tick. A word is accepted every clock cycle
// when the response side keeps up; it passes an input register, the slot
// sequencing (phase, timer and shift update) and then a response register.
// All slot times are set through the csr port, which is always ready and should
// be written only while idle.
module one_wire_master (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  owm_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output owm_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [owm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [owm_pkg::CFG_W-1:0]        csr_data
);
   import owm_pkg::*;
   `include "one_wire_master_defines.svh"

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    advance;
   logic    take;
   cfg_type cfg;
   rsp_type step_rsp;

   owm_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   owm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   // move a word into the response register when it is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = step_rsp;
         in_valid_in  = 1'b0;
      end
      if (take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `OWM_ASSERT_NOW(a_stall_only_on_backpressure, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without response backpressure")
   `OWM_ASSERT_NOW(a_drive_only_when_busy, clock, reset, rsp_valid && rsp_data.drive_low, rsp_data.busy_res, "line driven low outside an operation")
   `OWM_ASSERT_NOW(a_done_only_when_busy, clock, reset, rsp_valid && rsp_data.done_res, rsp_data.busy_res, "done outside an operation")
   `OWM_ASSERT_NEXT(a_held_word_advances, clock, reset, in_valid_ff && !rsp_valid, rsp_valid, "held request word did not reach the response register")

endmodule

>>> test/one_wire_master_test.sv
// Self-checking testbench of the one-wire master: timed slots, presence and data, stalls.
module one_wire_master_test;
   timeunit 1ns;
   timeprecision 1ps;

   import owm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LINE_RANDOM = 0;
   localparam int LINE_LOW    = 1;
   localparam int LINE_HIGH   = 2;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CFG_W-1:0]       csr_data;

   // bus timing and operation state as the block should hold it
   cfg_word_type timing [8];
   phase_type    bus_phase;
   op_type       bus_op;
   time_type     slot_timer;
   logic [3:0]   bits_to_go;
   logic [7:0]   tx_shift;
   logic [7:0]   rx_shift;
   logic         presence_flag;

   rsp_type tick_results [$];
   int      failures = 0;
   int      words_sent = 0;
   int      hold_request = 0;
   bit      idling = 1'b1;

   one_wire_master u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic time_type phase_length(input phase_type p);
      time_type v;
      bit       rst;
      rst = (bus_op == OP_RESET);
      case (p)
         PH_LOW: begin
            v = rst ? timing[CSR_RESET_LOW] : timing[CSR_SLOT_LOW];
            if (v == '0) v = time_type'(1);
         end
         PH_WAIT: begin
            if (rst) begin
               v = timing[CSR_PRESENCE_DELAY];
               if (v == '0) v = time_type'(1);
            end else begin
               v = timing[CSR_READ_DELAY];
            end
         end
         PH_SAMPLE: v = time_type'(1);
         PH_TAIL: v = rst ? timing[CSR_RESET_RECOVERY] : timing[CSR_READ_TAIL];
         PH_HOLD: begin
            v = timing[CSR_WRITE_HOLD];
            if (v == '0) v = time_type'(1);
         end
         PH_WREC: v = timing[CSR_WRITE_RECOVERY];
         default: v = '0;
      endcase
      return v;
   endfunction

   // PH_IDLE as a successor means the bit slot is over
   function automatic phase_type phase_after(input phase_type p);
      bit wr;
      wr = (bus_op == OP_WBYTE || bus_op == OP_WBIT);
      case (p)
         PH_LOW:    return wr ? PH_HOLD : PH_WAIT;
         PH_WAIT:   return PH_SAMPLE;
         PH_SAMPLE: return PH_TAIL;
         PH_HOLD:   return PH_WREC;
         default:   return PH_IDLE;
      endcase
   endfunction

   // step into phase p, passing over empty phases; 1 when the operation ends
   function automatic bit enter_phase(input phase_type first);
      phase_type p;
      time_type  d;
      bit        settled;
      bit        finished;
      p = first;
      settled = 1'b0;
      finished = 1'b0;
      while (!settled) begin
         if (p == PH_IDLE) begin
            bits_to_go = bits_to_go - 4'd1;
            tx_shift = tx_shift >> 1;
            if (bits_to_go == 4'd0) begin
               bus_phase = PH_IDLE;
               slot_timer = '0;
               finished = 1'b1;
               settled = 1'b1;
            end else begin
               p = PH_LOW;
            end
         end else begin
            d = phase_length(p);
            if (d == '0) begin
               p = phase_after(p);
            end else begin
               bus_phase = p;
               slot_timer = d;
               settled = 1'b1;
            end
         end
      end
      return finished;
   endfunction

   // advance the bus by one tick and return the word the block should answer with
   function automatic rsp_type bus_tick(input req_type w);
      rsp_type    r;
      logic [3:0] total;
      logic [2:0] idx;
      r = '0;
      if (bus_phase == PH_IDLE && w.start_req && w.mode <= OP_WBIT) begin
         bus_op = op_type'(w.mode);
         bits_to_go = (bus_op == OP_WBYTE || bus_op == OP_RBYTE) ? 4'(BITS_PER_BYTE) : 4'd1;
         tx_shift = (bus_op == OP_WBIT) ? {7'd0, w.tx_value[0]} : w.tx_value;
         if (bus_op == OP_RBYTE || bus_op == OP_RBIT) rx_shift = '0;
         if (bus_op == OP_RESET) presence_flag = 1'b0;
         void'(enter_phase(PH_LOW));
      end
      if (bus_phase != PH_IDLE) begin
         r.busy_res = 1'b1;
         if (bus_phase == PH_LOW) begin
            r.drive_low = 1'b1;
         end else if (bus_phase == PH_HOLD) begin
            r.drive_low = ~tx_shift[0];
         end
         if (bus_phase == PH_SAMPLE) begin
            if (bus_op == OP_RESET) begin
               presence_flag = ~w.line_in;
            end else begin
               total = (bus_op == OP_RBYTE) ? 4'(BITS_PER_BYTE) : 4'd1;
               idx = 3'(total - bits_to_go);
               rx_shift = rx_shift | (8'(w.line_in) << idx);
            end
         end
         slot_timer = slot_timer - time_type'(1);
         if (slot_timer == '0) r.done_res = enter_phase(phase_after(bus_phase));
      end
      r.presence = presence_flag;
      r.rx_value = rx_shift;
      return r;
   endfunction

   function automatic logic line_level(input int pattern);
      if (pattern == LINE_LOW) return 1'b0;
      if (pattern == LINE_HIGH) return 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         failures++;
      end
   endfunction

   task automatic send_word(input req_type w);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick_results.push_back(bus_tick(w));
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tick_results.size() != 0);
   endtask

   // write all eight timing registers back to back; only while the bus is idle
   task automatic write_timing(input cfg_word_type v [8]);
      for (int i = 0; i < 8; i++) begin
         csr_index <= csr_index_type'(i);
         csr_data <= v[i];
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         timing[i] = v[i];
      end
      csr_valid <= 1'b0;
   endtask

   // start one operation, then keep ticking with noise until the bus is idle again
   task automatic run_op(input logic [2:0] mode, input logic [7:0] tx, input int pattern);
      req_type w;
      w.start_req = 1'b1;
      w.mode = mode;
      w.tx_value = tx;
      w.line_in = line_level(pattern);
      send_word(w);
      while (bus_phase != PH_IDLE) begin
         w.start_req = 1'($urandom_range(0, 1));
         w.mode = 3'($urandom_range(0, 7));
         w.tx_value = 8'($urandom_range(0, 255));
         w.line_in = line_level(pattern);
         send_word(w);
      end
   endtask

   task automatic idle_ticks(input int count);
      req_type w;
      for (int i = 0; i < count; i++) begin
         w.mode = 3'($urandom_range(0, 7));
         w.start_req = (w.mode > OP_WBIT) ? 1'($urandom_range(0, 1)) : 1'b0;
         w.tx_value = 8'($urandom_range(0, 255));
         w.line_in = 1'($urandom_range(0, 1));
         send_word(w);
      end
   endtask

   task automatic random_op(input int pattern);
      logic [2:0] mode;
      mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      idle_ticks($urandom_range(0, 2));
      run_op(mode, 8'($urandom_range(0, 255)), pattern);
   endtask

   task automatic random_timing();
      cfg_word_type v [8];
      foreach (v[i]) begin
         v[i] = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 40))
                                            : CFG_W'($urandom_range(0, 6));
      end
      write_timing(v);
   endtask

   task automatic test_default_timing();
      run_op(OP_RESET, 8'h00, LINE_RANDOM);
      run_op(OP_RBIT, 8'h00, LINE_RANDOM);
      run_op(OP_WBIT, 8'hA4, LINE_RANDOM);
      drain();
   endtask

   // all zero: low times, holds and the presence delay act as one; read waits, read tails and recoveries drop out
   task automatic test_directed();
      cfg_word_type v [8];
      foreach (v[i]) v[i] = '0;
      write_timing(v);
      idle_ticks(1);
      run_op(3'd5, 8'hFF, LINE_RANDOM);
      run_op(3'd6, 8'h00, LINE_RANDOM);
      run_op(3'd7, 8'h55, LINE_RANDOM);
      run_op(OP_RESET, 8'h00, LINE_LOW);
      run_op(OP_RESET, 8'hFF, LINE_HIGH);
      run_op(OP_WBYTE, 8'h00, LINE_RANDOM);
      run_op(OP_WBYTE, 8'hFF, LINE_RANDOM);
      run_op(OP_RBYTE, 8'h00, LINE_HIGH);
      run_op(OP_RBYTE, 8'hFF, LINE_LOW);
      run_op(OP_RBIT, 8'h00, LINE_HIGH);
      run_op(OP_RBIT, 8'h00, LINE_LOW);
      run_op(OP_WBIT, 8'hFE, LINE_RANDOM);
      run_op(OP_WBIT, 8'h01, LINE_RANDOM);
      drain();
   endtask

   // hold off the response side while requests keep coming, so the input backs up
   task automatic test_backpressure();
      int first;
      random_timing();
      first = words_sent;
      hold_request = 300;
      while (words_sent - first < 200) random_op(LINE_RANDOM);
      drain();
   endtask

   task automatic test_random();
      int first;
      for (int ph = 0; ph < 2; ph++) begin
         if (ph == 1) idling = 1'b0;
         random_timing();
         first = words_sent;
         while (words_sent - first < 200) random_op(LINE_RANDOM);
         drain();
      end
   endtask

   initial begin : response_side
      int      stall_left;
      rsp_type want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (tick_results.size() == 0) begin
               $display("%0t: response word with none expected, got %p", $time, rsp_data);
               failures++;
            end else begin
               want = tick_results.pop_front();
               check_field("drive_low", want.drive_low, rsp_data.drive_low);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("presence", want.presence, rsp_data.presence);
               check_field("rx_value", want.rx_value, rsp_data.rx_value);
            end
         end
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("one_wire_master_test failed");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_RESET_LOW;
      csr_data <= '0;
      timing[CSR_RESET_LOW] = 10'd480;
      timing[CSR_PRESENCE_DELAY] = 10'd100;
      timing[CSR_RESET_RECOVERY] = 10'd380;
      timing[CSR_SLOT_LOW] = 10'd2;
      timing[CSR_READ_DELAY] = 10'd10;
      timing[CSR_READ_TAIL] = 10'd49;
      timing[CSR_WRITE_HOLD] = 10'd58;
      timing[CSR_WRITE_RECOVERY] = 10'd1;
      bus_phase = PH_IDLE;
      bus_op = OP_RESET;
      slot_timer = '0;
      bits_to_go = '0;
      tx_shift = '0;
      rx_shift = '0;
      presence_flag = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_default_timing();
      test_directed();
      test_backpressure();
      test_random();
      drain();
      // let any stray response words show up
      repeat (8) @(posedge clock);
      if (failures == 0 && tick_results.size() == 0) begin
         $display("one_wire_master_test passed");
      end else begin
         $display("one_wire_master_test failed");
      end
      $finish;
   end

endmodule

>>> one_wire_master.f
+incdir+src
src/owm_pkg.sv
src/owm_cfg_regs.sv
src/owm_core.sv
src/one_wire_master.sv
test/one_wire_master_test.sv
